[sv/qmr_pkg.sv]
// types, widths and scaling helpers shared by the quaternion unit
`timescale 1ns / 1ps

package qmr_pkg;

  localparam int COMP_W = 16;                 // q2.14 component
  localparam int WIDE_W = 17;                 // second operand, holds +32768
  localparam int PROD_W = COMP_W + WIDE_W;    // one exact product
  localparam int SUM_W  = PROD_W + 2;         // sum of four products
  localparam int FRAC_BITS = 14;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [WIDE_W-1:0] wcomp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef comp_t  [3:0] quat_t;
  typedef wcomp_t [3:0] wquat_t;

  typedef struct packed {
    comp_t val;
    logic  clip;
  } scaled_t;

  localparam sum_t SAT_MAX = sum_t'(32767);
  localparam sum_t SAT_MIN = -sum_t'(32768);

  // floor shift by the fraction bits, then clamp to 16 bits
  function automatic scaled_t scale_sat(input sum_t s);
    sum_t    sh;
    scaled_t res;
    sh = s >>> FRAC_BITS;
    if (sh > SAT_MAX) begin
      res.val  = comp_t'(SAT_MAX);
      res.clip = 1'b1;
    end else if (sh < SAT_MIN) begin
      res.val  = comp_t'(SAT_MIN);
      res.clip = 1'b1;
    end else begin
      res.val  = sh[COMP_W-1:0];
      res.clip = 1'b0;
    end
    return res;
  endfunction

endpackage

[sv/qmr_ham.sv]
// two-stage hamilton product: registered products, then registered sum and clamp
`timescale 1ns / 1ps

module qmr_ham import qmr_pkg::*; (
  input  logic   clk,
  input  logic   ld_prod,
  input  logic   ld_sum,
  input  logic   want_w,
  input  quat_t  p,
  input  wquat_t q,
  output quat_t  r,
  output logic   flag
);

  prod_t   prod [4][4];
  logic    want_w_q;
  sum_t    sum  [4];
  scaled_t sc   [4];

  always_ff @(posedge clk) begin
    if (ld_prod) begin
      want_w_q <= want_w;
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          prod[j][k] <= $signed(p[j]) * $signed(q[k]);
        end
      end
    end
  end

  always_comb begin
    sum[0] = sum_t'(prod[0][0]) - sum_t'(prod[1][1]) - sum_t'(prod[2][2]) - sum_t'(prod[3][3]);
    sum[1] = sum_t'(prod[0][1]) + sum_t'(prod[1][0]) + sum_t'(prod[2][3]) - sum_t'(prod[3][2]);
    sum[2] = sum_t'(prod[0][2]) - sum_t'(prod[1][3]) + sum_t'(prod[2][0]) + sum_t'(prod[3][1]);
    sum[3] = sum_t'(prod[0][3]) + sum_t'(prod[1][2]) - sum_t'(prod[2][1]) + sum_t'(prod[3][0]);
    for (int i = 0; i < 4; i++) begin
      sc[i] = scale_sat(sum[i]);
    end
  end

  // scalar skipped when not wanted: zero and no clamp check
  always_ff @(posedge clk) begin
    if (ld_sum) begin
      r[0] <= want_w_q ? sc[0].val : '0;
      r[1] <= sc[1].val;
      r[2] <= sc[2].val;
      r[3] <= sc[3].val;
      flag <= (want_w_q & sc[0].clip) | sc[1].clip | sc[2].clip | sc[3].clip;
    end
  end

endmodule

[sv/quaternion_multiply_rotate.sv]
// top level: quaternion product and vector rotation, four-stage pipeline
`timescale 1ns / 1ps
//
// channel  dir  width     contents
// s_axis   in   128 + 1   tdata: a_w a_x a_y a_z b_w b_x b_y b_z, tuser: req_type
// m_axis   out  64 + 1    tdata: r_w r_x r_y r_z, tuser: saturated
//
// one item per cycle sustained while m_axis_tready stays high; an accepted item moves
// through the stage 1 to stage 4 registers before m_axis_tvalid rises
// stage 1 first product terms, stage 2 first sum and clamp, stage 3 second product
// terms (against conj(a)), stage 4 second sum and clamp into the output register
// rst clears only the valid bits; payload registers are not reset
// each stage loads whenever it is empty or the stage after it moves, so a stall
// at m_axis backs up stage by stage and bubbles still close up

module quaternion_multiply_rotate import qmr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic         s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // r_w, r_x, r_y, r_z
  output logic         m_axis_tuser    // saturated
);

  localparam logic REQ_PRODUCT = 1'b0;
  localparam logic REQ_ROTATE  = 1'b1;

  // stage valid bits and load enables
  logic v1, v2, v3, v4;
  logic ld1, ld2, ld3, ld4;

  // operand unpack
  quat_t  a_in;
  quat_t  b_in;
  wquat_t q1;

  // sideband carried along the pipe
  logic   mode1, mode2, mode3, mode4;
  quat_t  a1, a2;
  quat_t  t3, t4;
  logic   f3, f4;

  // unit results
  quat_t  t;
  logic   t_flag;
  wquat_t conj_a;
  quat_t  rot;
  logic   rot_flag;

  assign ld4 = !v4 || m_axis_tready;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign s_axis_tready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) v1 <= s_axis_tvalid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_in[i] = s_axis_tdata[COMP_W*i +: COMP_W];
      b_in[i] = s_axis_tdata[COMP_W*(i+4) +: COMP_W];
    end
    // rotate mode feeds the pure quaternion (0, v)
    q1[0] = (s_axis_tuser == REQ_ROTATE) ? '0 : wcomp_t'(b_in[0]);
    for (int i = 1; i < 4; i++) begin
      q1[i] = wcomp_t'(b_in[i]);
    end
    // conjugate held at 17 bits so negating -32768 stays exact
    conj_a[0] = wcomp_t'(a2[0]);
    for (int i = 1; i < 4; i++) begin
      conj_a[i] = -wcomp_t'(a2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      mode1 <= s_axis_tuser;
      a1    <= a_in;
    end
    if (ld2) begin
      mode2 <= mode1;
      a2    <= a1;
    end
    if (ld3) begin
      mode3 <= mode2;
      t3    <= t;
      f3    <= t_flag;
    end
    if (ld4) begin
      mode4 <= mode3;
      t4    <= t3;
      f4    <= f3;
    end
  end

  // first product: a*b, or a*(0,v)
  qmr_ham u_ham_first (
    .clk     (clk),
    .ld_prod (ld1),
    .ld_sum  (ld2),
    .want_w  (1'b1),
    .p       (a_in),
    .q       (q1),
    .r       (t),
    .flag    (t_flag)
  );

  // second product: t*conj(a), scalar not needed
  qmr_ham u_ham_second (
    .clk     (clk),
    .ld_prod (ld3),
    .ld_sum  (ld4),
    .want_w  (1'b0),
    .p       (t),
    .q       (conj_a),
    .r       (rot),
    .flag    (rot_flag)
  );

  always_comb begin
    case (mode4)
      REQ_PRODUCT: begin
        m_axis_tdata = {t4[3], t4[2], t4[1], t4[0]};
        m_axis_tuser = f4;
      end
      REQ_ROTATE: begin
        m_axis_tdata = {rot[3], rot[2], rot[1], comp_t'(0)};
        m_axis_tuser = f4 | rot_flag;
      end
      default: begin
        m_axis_tdata = '0;
        m_axis_tuser = 1'b0;
      end
    endcase
  end

  assign m_axis_tvalid = v4;

endmodule
